>>> sv/htc_pkg.sv
// Shared types, register indexes and constants of the hysteresis thermostat controller.
package htc_pkg;

  localparam int TempWidth     = 12;
  localparam int SetpointWidth = 10;
  localparam int DeadbandWidth = 12;
  localparam int HoldWidth     = 10;
  localparam int PressWidth    = 5;
  localparam int FactorWidth   = 16;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  localparam logic signed [SetpointWidth-1:0] SETPOINT_MIN   = -10'sd300;
  localparam logic signed [SetpointWidth-1:0] SETPOINT_MAX   = 10'sd300;
  localparam logic signed [SetpointWidth-1:0] SETPOINT_RESET = 10'sd150;
  localparam logic [DeadbandWidth-1:0]        DEADBAND_RESET = 12'd10;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] REG_DEADBAND_FACTOR = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_MIN_DEADBAND    = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_COOL_OFFSET     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_HEAT_OFFSET     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_AMBIENT_BAND    = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_HOLD_COUNT      = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_BUTTON_DEBOUNCE = 3'd6;

  // Button codes.
  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_RAISE  = 2'd1;
  localparam logic [1:0] BTN_LOWER  = 2'd2;
  localparam logic [1:0] BTN_TOGGLE = 2'd3;

  typedef struct packed {
    logic [FactorWidth-1:0] deadband_factor_q16;
    logic [7:0]             min_deadband;
    logic signed [8:0]      cool_offset;
    logic signed [8:0]      heat_offset;
    logic [7:0]             ambient_band;
    logic [HoldWidth-1:0]   hold_count;
    logic [3:0]             button_debounce;
  } htc_cfg_t;

  // Packed so that the first field sits in the highest bits.
  typedef struct packed {
    logic [DeadbandWidth-1:0]        deadband_now;
    logic signed [SetpointWidth-1:0] setpoint_now;
    logic                            target_reached;
    logic                            is_active;
    logic                            cooler_on;
    logic                            heater_on;
  } htc_result_t;

endpackage

>>> sv/htc_pass.sv
// Controller state and the combinational logic of one control pass.
module htc_pass (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step,
  input  htc_pkg::htc_cfg_t                    cfg,
  input  logic signed [htc_pkg::TempWidth-1:0] measured_temp,
  input  logic signed [htc_pkg::TempWidth-1:0] ambient_temp,
  input  logic [1:0]                           button,
  output htc_pkg::htc_result_t                 result
);
  import htc_pkg::*;

  logic signed [SetpointWidth-1:0] setpoint, setpoint_next;
  logic [DeadbandWidth-1:0]        deadband, deadband_next;
  logic                            active_flag, active_flag_next;
  logic                            reached_flag, reached_flag_next;
  logic [HoldWidth-1:0]            hold_counter, hold_counter_next;
  logic [PressWidth-1:0]           press_counter, press_counter_next;
  logic                            heater_state, heater_state_next;
  logic                            cooler_state, cooler_state_next;

  logic                  act, recompute;
  logic [PressWidth-1:0] press_inc, debounce5;
  logic signed [12:0]    err;
  logic signed [29:0]    product;
  logic [DeadbandWidth-1:0] deadband_calc;
  logic signed [13:0]    meas14, amb14, sp14, db14, cool14, heat14, min14, band14;
  logic                  too_warm, too_cold, near_target;

  always_comb begin
    press_inc = press_counter + 5'd1;
    debounce5 = {1'b0, cfg.button_debounce};
    press_counter_next = press_counter;
    act = 1'b0;
    if (button == BTN_NONE) begin
      press_counter_next = '0;
    end else if (press_counter < debounce5 + 5'd1) begin
      if (press_inc >= debounce5) begin
        press_counter_next = press_inc + 5'd1;
        act = 1'b1;
      end else begin
        press_counter_next = press_inc;
      end
    end

    setpoint_next     = setpoint;
    active_flag_next  = active_flag;
    reached_flag_next = reached_flag;
    recompute         = 1'b0;
    if (act) begin
      unique case (button)
        BTN_RAISE: begin
          if (setpoint < SETPOINT_MAX) setpoint_next = setpoint + 10'sd1;
          recompute = 1'b1;
          reached_flag_next = 1'b0;
        end
        BTN_LOWER: begin
          if (setpoint > SETPOINT_MIN) setpoint_next = setpoint - 10'sd1;
          recompute = 1'b1;
          reached_flag_next = 1'b0;
        end
        BTN_TOGGLE: begin
          if (active_flag) begin
            active_flag_next = 1'b0;
          end else begin
            active_flag_next = 1'b1;
            recompute = 1'b1;
            reached_flag_next = 1'b0;
          end
        end
        default: ;
      endcase
    end

    // A negative error always floors to the minimum deadband, so truncation
    // toward zero only matters for nonnegative products, where it is a shift.
    err     = {{3{setpoint_next[SetpointWidth-1]}}, setpoint_next}
            - {measured_temp[TempWidth-1], measured_temp};
    product = {{17{err[12]}}, err} * $signed({14'd0, cfg.deadband_factor_q16});
    if (product[29] || (product[28:16] < {5'd0, cfg.min_deadband})) begin
      deadband_calc = {4'd0, cfg.min_deadband};
    end else begin
      deadband_calc = product[27:16];
    end
    deadband_next = recompute ? deadband_calc : deadband;

    meas14 = {{2{measured_temp[TempWidth-1]}}, measured_temp};
    amb14  = {{2{ambient_temp[TempWidth-1]}}, ambient_temp};
    sp14   = {{4{setpoint_next[SetpointWidth-1]}}, setpoint_next};
    db14   = {2'd0, deadband_next};
    cool14 = {{5{cfg.cool_offset[8]}}, cfg.cool_offset};
    heat14 = {{5{cfg.heat_offset[8]}}, cfg.heat_offset};
    min14  = {6'd0, cfg.min_deadband};
    band14 = {6'd0, cfg.ambient_band};

    too_warm    = meas14 > sp14 + db14 + cool14;
    too_cold    = meas14 < sp14 - db14 - heat14;
    near_target = (meas14 > sp14 - min14) && (meas14 < sp14 + min14);

    heater_state_next = heater_state;
    cooler_state_next = cooler_state;
    hold_counter_next = hold_counter;
    if (!active_flag_next) begin
      heater_state_next = 1'b0;
      cooler_state_next = 1'b0;
      hold_counter_next = cfg.hold_count;
    end else if (too_warm) begin
      if (hold_counter >= cfg.hold_count) begin
        if ((sp14 < amb14 + band14) || !reached_flag_next) cooler_state_next = 1'b1;
        heater_state_next = 1'b0;
      end else begin
        hold_counter_next = hold_counter + 10'd1;
      end
    end else if (too_cold) begin
      if (hold_counter >= cfg.hold_count) begin
        if ((sp14 > amb14 - band14) || !reached_flag_next) heater_state_next = 1'b1;
        cooler_state_next = 1'b0;
      end else begin
        hold_counter_next = hold_counter + 10'd1;
      end
    end else if (hold_counter == '0) begin
      heater_state_next = 1'b0;
      cooler_state_next = 1'b0;
      if (near_target) begin
        deadband_next     = {4'd0, cfg.min_deadband};
        reached_flag_next = 1'b1;
      end
    end else begin
      hold_counter_next = hold_counter - 10'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint      <= SETPOINT_RESET;
      deadband      <= DEADBAND_RESET;
      active_flag   <= 1'b0;
      reached_flag  <= 1'b0;
      hold_counter  <= '0;
      press_counter <= '0;
      heater_state  <= 1'b0;
      cooler_state  <= 1'b0;
    end else if (step) begin
      setpoint      <= setpoint_next;
      deadband      <= deadband_next;
      active_flag   <= active_flag_next;
      reached_flag  <= reached_flag_next;
      hold_counter  <= hold_counter_next;
      press_counter <= press_counter_next;
      heater_state  <= heater_state_next;
      cooler_state  <= cooler_state_next;
    end
  end

  always_comb begin
    result.heater_on      = heater_state_next;
    result.cooler_on      = cooler_state_next;
    result.is_active      = active_flag_next;
    result.target_reached = reached_flag_next;
    result.setpoint_now   = setpoint_next;
    result.deadband_now   = deadband_next;
  end

endmodule

>>> sv/hysteresis_thermostat_control.sv
// Top level of the hysteresis thermostat controller: handshakes, registers, pass logic.
//
//  Channel   Direction  Carries                                  Word accepted when
//  s_axis    in         measured/ambient temp, button in tuser   s_tvalid && s_tready
//  m_axis    out        drives, flags, setpoint, deadband        m_tvalid && m_tready
//  cfg       in         register index and write data            cfg_valid && cfg_ready
//
// A word passes from the input register through the pass logic into the output
// register, and one word is taken every cycle while m_tready is high. The pass
// logic (one 13x17 multiply followed by the band compares) is the longest path.
// Reset restores the register defaults and the controller state.
// A stall on m_tready holds the result; the input register still takes one more word.
module hysteresis_thermostat_control (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [23:0]                         s_tdata,  // measured_temp[11:0], ambient_temp[23:12]
  input  logic [1:0]                          s_tuser,  // button[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // heater_on[0], cooler_on[1], is_active[2], target_reached[3],
  // setpoint_now[13:4], deadband_now[25:14], zero fill[31:26]
  output logic [31:0]                         m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [htc_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [htc_pkg::CfgDataWidth-1:0]    cfg_data
);
  import htc_pkg::*;

  htc_cfg_t    cfg;
  htc_result_t result;

  logic                        in_valid;
  logic signed [TempWidth-1:0] in_measured;
  logic signed [TempWidth-1:0] in_ambient;
  logic [1:0]                  in_button;
  logic                        out_free, step;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign step      = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.deadband_factor_q16 <= 16'd9830;
      cfg.min_deadband        <= 8'd2;
      cfg.cool_offset         <= '0;
      cfg.heat_offset         <= '0;
      cfg.ambient_band        <= 8'd20;
      cfg.hold_count          <= 10'd100;
      cfg.button_debounce     <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEADBAND_FACTOR: cfg.deadband_factor_q16 <= cfg_data;
        REG_MIN_DEADBAND:    cfg.min_deadband        <= cfg_data[7:0];
        REG_COOL_OFFSET:     cfg.cool_offset         <= cfg_data[8:0];
        REG_HEAT_OFFSET:     cfg.heat_offset         <= cfg_data[8:0];
        REG_AMBIENT_BAND:    cfg.ambient_band        <= cfg_data[7:0];
        REG_HOLD_COUNT:      cfg.hold_count          <= cfg_data[9:0];
        REG_BUTTON_DEBOUNCE: cfg.button_debounce     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_measured <= s_tdata[11:0];
      in_ambient  <= s_tdata[23:12];
      in_button   <= s_tuser;
    end
  end

  htc_pass u_pass (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .cfg           (cfg),
    .measured_temp (in_measured),
    .ambient_temp  (in_ambient),
    .button        (in_button),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {6'd0, result};
    end
  end

endmodule

>>> sv/htc_checker.sv
// Port-level checks of the thermostat controller, bound to the top level.
module htc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A result word that is not taken stays on the bus unchanged.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed or dropped");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("heater and cooler both on");

  a_idle_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> !m_tdata[0] && !m_tdata[1])
    else $error("drive on while control is inactive");

  a_setpoint_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[13:4]) >= -10'sd300) && ($signed(m_tdata[13:4]) <= 10'sd300))
    else $error("setpoint outside its clamp range");

endmodule

bind hysteresis_thermostat_control htc_checker u_htc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
